### src/iipd_pkg.sv
// ---------------------------------------------------------------------------
// iipd_pkg: shared types and constants for the indexed image decoder
// File layout offsets, result codes, the parser phase type and the result slot type.
// ---------------------------------------------------------------------------
package iipd_pkg;

  // palette storage
  localparam int PAL_ADDR_W  = 8;
  localparam int PAL_DATA_W  = 24;

  // file layout
  localparam logic [7:0] MAGIC0        = 8'h19;
  localparam logic [7:0] MAGIC1        = 8'h91;
  localparam int         PAL_START     = 32;
  localparam int         PAL_ENTRIES   = 256;
  localparam int         PAL_COMPS     = 3;
  localparam int         PAL_END       = PAL_START + PAL_ENTRIES * PAL_COMPS;
  localparam int         OFF_W         = 10;

  localparam logic [OFF_W-1:0] OFF_MAGIC0  = OFF_W'(0);
  localparam logic [OFF_W-1:0] OFF_MAGIC1  = OFF_W'(1);
  localparam logic [OFF_W-1:0] OFF_WIDTH_L = OFF_W'(2);
  localparam logic [OFF_W-1:0] OFF_WIDTH_H = OFF_W'(3);
  localparam logic [OFF_W-1:0] OFF_HEIGHT_L = OFF_W'(4);
  localparam logic [OFF_W-1:0] OFF_HEIGHT_H = OFF_W'(5);
  localparam logic [OFF_W-1:0] OFF_HDR_LAST = OFF_W'(PAL_START - 1);
  localparam logic [OFF_W-1:0] OFF_PAL_LAST = OFF_W'(PAL_END - 1);

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_HDR_SHORT = 3'd1;
  localparam logic [2:0] ST_ZERO_SIZE = 3'd2;
  localparam logic [2:0] ST_PAL_SHORT = 3'd3;
  localparam logic [2:0] ST_PIX_SHORT = 3'd4;

  // palette component position
  localparam logic [1:0] COMP_RED   = 2'd0;
  localparam logic [1:0] COMP_GREEN = 2'd1;
  localparam logic [1:0] COMP_BLUE  = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PALETTE = 2'd1,
    PH_PIXELS  = 2'd2,
    PH_IGNORE  = 2'd3
  } iipd_phase_t;

  // results caused by one byte: a first result, optionally followed by an error
  typedef struct packed {
    logic [1:0]  kind0;
    logic [15:0] width;
    logic [15:0] height;
    logic        magic;
    logic        last_px;
    logic [2:0]  st0;
    logic        has2;
    logic [2:0]  st1;
  } iipd_slot_t;

endpackage

### src/indexed_image_palette_decoder.sv
// ---------------------------------------------------------------------------
// indexed_image_palette_decoder: byte-stream decoder for 8-bit indexed images
// A byte's first result goes through the result slot, then the output register.
// One byte per cycle while out_ready is high; a byte with two results (header plus
//   error, pixel plus error) holds the input until its second result moves to the output register.
// Reset: synchronous, active low; clears the parser and both result stages.
//   Palette contents are not cleared.
// ---------------------------------------------------------------------------
module indexed_image_palette_decoder
  import iipd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input byte stream
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_file_byte,
  input  logic        in_end_of_file,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [15:0] out_image_width,
  output logic [15:0] out_image_height,
  output logic        out_magic_ok,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_last_pixel,
  output logic [2:0]  out_status,
  output logic        out_last_of_run
);

  // -------------------------------------------------------------------------
  // Parser state
  // -------------------------------------------------------------------------
  iipd_phase_t            phase_r, phase_nxt;
  logic [OFF_W-1:0]       off_r, off_nxt;
  logic [15:0]            width_r, width_nxt;
  logic [15:0]            height_r, height_nxt;
  logic                   magic_r, magic_nxt;
  logic [15:0]            cpart_r, cpart_nxt;   // red/green of the entry in flight
  logic [1:0]             comp_r, comp_nxt;     // component within palette entry
  logic [PAL_ADDR_W-1:0]  ent_r, ent_nxt;       // palette entry being written
  logic [15:0]            col_r, col_nxt;
  logic [15:0]            row_r, row_nxt;

  // decode stage: results of the accepted byte, waiting for the output register
  iipd_slot_t slot_r, slot_nxt;
  logic       slot_v_r;
  logic       slot_sel_r;   // 1: first result already sent, second pending
  logic       any_res;

  // palette port
  logic                   pal_we;
  logic                   pal_re;
  logic [PAL_DATA_W-1:0]  pal_rdata;

  logic in_acc;
  logic move;       // slot result moves into the output register
  logic slot_done;  // that move empties the slot

  logic [15:0] height_new;
  logic        zero_sz;
  logic        last_px;
  logic [15:0] col_inc;

  // -------------------------------------------------------------------------
  // Handshake
  // -------------------------------------------------------------------------
  assign move      = slot_v_r && (!out_valid || out_ready);
  assign slot_done = move && (slot_sel_r || !slot_r.has2);
  assign in_ready  = !slot_v_r || slot_done;
  assign in_acc    = in_valid && in_ready;

  assign height_new = {in_file_byte, height_r[7:0]};
  assign zero_sz    = (width_r == 16'd0) || (height_new == 16'd0);
  assign last_px    = (({1'b0, col_r} + 17'd1) == {1'b0, width_r}) &&
                      (({1'b0, row_r} + 17'd1) == {1'b0, height_r});
  assign col_inc    = col_r + 16'd1;

  // -------------------------------------------------------------------------
  // Byte decode
  // -------------------------------------------------------------------------
  always_comb begin
    phase_nxt  = phase_r;
    off_nxt    = off_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    magic_nxt  = magic_r;
    cpart_nxt  = cpart_r;
    comp_nxt   = comp_r;
    ent_nxt    = ent_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    slot_nxt   = '0;
    any_res    = 1'b0;
    pal_we     = 1'b0;
    pal_re     = 1'b0;

    case (phase_r)
      PH_HEADER: begin
        off_nxt = off_r + OFF_W'(1);
        if (off_r == OFF_MAGIC0) begin
          magic_nxt = (in_file_byte == MAGIC0);
        end else if (off_r == OFF_MAGIC1) begin
          magic_nxt = magic_r && (in_file_byte == MAGIC1);
        end else if (off_r == OFF_WIDTH_L) begin
          width_nxt = {8'h00, in_file_byte};
        end else if (off_r == OFF_WIDTH_H) begin
          width_nxt = {in_file_byte, width_r[7:0]};
        end else if (off_r == OFF_HEIGHT_L) begin
          height_nxt = {8'h00, in_file_byte};
        end else if (off_r == OFF_HEIGHT_H) begin
          height_nxt     = height_new;
          any_res        = 1'b1;
          slot_nxt.kind0 = KIND_HEADER;
          slot_nxt.width = width_r;
          slot_nxt.height = height_new;
          slot_nxt.magic = magic_r;
        end
        if (off_r == OFF_HDR_LAST) begin
          phase_nxt = PH_PALETTE;
        end
        if (off_r == OFF_HEIGHT_H && zero_sz) begin
          slot_nxt.has2 = 1'b1;
          slot_nxt.st1  = ST_ZERO_SIZE;
          phase_nxt     = PH_IGNORE;
        end else if (in_end_of_file) begin
          if (off_r == OFF_HEIGHT_H) begin
            slot_nxt.has2 = 1'b1;
            slot_nxt.st1  = ST_PAL_SHORT;
          end else begin
            any_res        = 1'b1;
            slot_nxt.kind0 = KIND_ERROR;
            slot_nxt.st0   = (off_r < OFF_HEIGHT_H) ? ST_HDR_SHORT : ST_PAL_SHORT;
          end
        end
      end
      PH_PALETTE: begin
        off_nxt = off_r + OFF_W'(1);
        case (comp_r)
          COMP_RED: begin
            cpart_nxt = {8'h00, in_file_byte};
            comp_nxt  = COMP_GREEN;
          end
          COMP_GREEN: begin
            cpart_nxt = {in_file_byte, cpart_r[7:0]};
            comp_nxt  = COMP_BLUE;
          end
          default: begin
            pal_we   = in_acc;
            comp_nxt = COMP_RED;
            ent_nxt  = ent_r + PAL_ADDR_W'(1);
          end
        endcase
        if (off_r == OFF_PAL_LAST) begin
          phase_nxt = PH_PIXELS;
          col_nxt   = 16'd0;
          row_nxt   = 16'd0;
        end
        if (in_end_of_file) begin
          any_res        = 1'b1;
          slot_nxt.kind0 = KIND_ERROR;
          slot_nxt.st0   = (off_r == OFF_PAL_LAST) ? ST_PIX_SHORT : ST_PAL_SHORT;
        end
      end
      PH_PIXELS: begin
        pal_re           = in_acc;
        any_res          = 1'b1;
        slot_nxt.kind0   = KIND_PIXEL;
        slot_nxt.last_px = last_px;
        if (last_px) begin
          phase_nxt = PH_IGNORE;
        end else begin
          if (col_inc >= width_r) begin
            col_nxt = 16'd0;
            row_nxt = row_r + 16'd1;
          end else begin
            col_nxt = col_inc;
          end
          if (in_end_of_file) begin
            slot_nxt.has2 = 1'b1;
            slot_nxt.st1  = ST_PIX_SHORT;
          end
        end
      end
      default: begin
        // trailing bytes: nothing to do
      end
    endcase

    // end of file returns the parser to its start state
    if (in_end_of_file) begin
      phase_nxt  = PH_HEADER;
      off_nxt    = '0;
      width_nxt  = '0;
      height_nxt = '0;
      magic_nxt  = 1'b0;
      cpart_nxt  = '0;
      comp_nxt   = COMP_RED;
      ent_nxt    = '0;
      col_nxt    = '0;
      row_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      off_r    <= '0;
      width_r  <= '0;
      height_r <= '0;
      magic_r  <= 1'b0;
      cpart_r  <= '0;
      comp_r   <= COMP_RED;
      ent_r    <= '0;
      col_r    <= '0;
      row_r    <= '0;
    end else if (in_acc) begin
      phase_r  <= phase_nxt;
      off_r    <= off_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      magic_r  <= magic_nxt;
      cpart_r  <= cpart_nxt;
      comp_r   <= comp_nxt;
      ent_r    <= ent_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Palette memory: written on each blue byte, read with the pixel index.
  // All entries of a file are written before its first pixel is read, so
  // read and write never meet on one entry.
  // -------------------------------------------------------------------------
  iipd_palette_ram #(
    .ADDR_W (PAL_ADDR_W),
    .DATA_W (PAL_DATA_W)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (ent_r),
    .wdata ({in_file_byte, cpart_r}),
    .re    (pal_re),
    .raddr (in_file_byte),
    .rdata (pal_rdata)
  );

  // -------------------------------------------------------------------------
  // Result slot: holds one or two results of a byte. The pixel color comes
  // from the palette read data, which lines up with the slot.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_v_r   <= 1'b0;
      slot_sel_r <= 1'b0;
    end else begin
      if (in_acc && any_res) begin
        slot_v_r   <= 1'b1;
        slot_sel_r <= 1'b0;
      end else if (slot_done) begin
        slot_v_r   <= 1'b0;
        slot_sel_r <= 1'b0;
      end else if (move) begin
        slot_sel_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && any_res) begin
      slot_r <= slot_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Output register
  // -------------------------------------------------------------------------
  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [15:0] owidth_r, oheight_r;
  logic        omagic_r;
  logic [PAL_DATA_W-1:0] rgb_r;
  logic        olast_px_r;
  logic [2:0]  status_r;
  logic        last_run_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      if (slot_sel_r) begin
        // trailing error report
        kind_r     <= KIND_ERROR;
        owidth_r   <= '0;
        oheight_r  <= '0;
        omagic_r   <= 1'b0;
        rgb_r      <= '0;
        olast_px_r <= 1'b0;
        status_r   <= slot_r.st1;
        last_run_r <= 1'b1;
      end else begin
        kind_r     <= slot_r.kind0;
        owidth_r   <= slot_r.width;
        oheight_r  <= slot_r.height;
        omagic_r   <= slot_r.magic;
        rgb_r      <= (slot_r.kind0 == KIND_PIXEL) ? pal_rdata : '0;
        olast_px_r <= slot_r.last_px;
        status_r   <= slot_r.st0;
        last_run_r <= !slot_r.has2;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_image_width  = owidth_r;
  assign out_image_height = oheight_r;
  assign out_magic_ok     = omagic_r;
  assign out_red          = rgb_r[7:0];
  assign out_green        = rgb_r[15:8];
  assign out_blue         = rgb_r[23:16];
  assign out_last_pixel   = olast_px_r;
  assign out_status       = status_r;
  assign out_last_of_run  = last_run_r;

endmodule

### src/iipd_palette_ram.sv
// ---------------------------------------------------------------------------
// iipd_palette_ram: palette storage
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module iipd_palette_ram
  import iipd_pkg::*;
#(
  parameter int ADDR_W = PAL_ADDR_W,
  parameter int DATA_W = PAL_DATA_W
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### tb/indexed_image_palette_decoder_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// indexed_image_palette_decoder_test: self-checking bench for the decoder
// Streams whole and cut-short image files into the decoder and checks every
// header, pixel and error transaction against a cycle-free model of the
// parser kept in a scoreboard. Both sides idle at random, and the result
// side holds off once for a long stretch so that the input backs up.
// ---------------------------------------------------------------------------
module indexed_image_palette_decoder_test;
  import iipd_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;  // cycles without any transaction
  localparam int LONG_HOLD      = 80;    // result-side hold-off, in cycles
  localparam int DRAIN_CYCLES   = 12;    // extra wait after the last owed result

  // how the two magic bytes of a file are made
  localparam int MAGIC_GOOD       = 0;
  localparam int MAGIC_BAD_FIRST  = 1;
  localparam int MAGIC_BAD_SECOND = 2;

  // one decoder result, as seen on the out_ ports
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] width;
    logic [15:0] height;
    logic        magic;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last_px;
    logic [2:0]  status;
    logic        last_run;
  } decoded_result_t;

  // -------------------------------------------------------------------------
  // Scoreboard: parser model plus the queue of results still owed
  // -------------------------------------------------------------------------
  class decode_scoreboard;
    iipd_phase_t           phase;
    logic [OFF_W-1:0]      offset;
    logic [15:0]           img_w;
    logic [15:0]           img_h;
    logic                  magic_seen;
    logic [15:0]           color_lo;     // {green, red} of the entry in flight
    logic [PAL_DATA_W-1:0] palette [PAL_ENTRIES];
    logic [15:0]           col;
    logic [15:0]           row;
    decoded_result_t       owed[$];
    int                    errors;
    int                    predicted;
    int                    checked;

    function new();
      clear_parser();
      errors    = 0;
      predicted = 0;
      checked   = 0;
    endfunction

    // parser state after reset or after an end-of-file byte; palette kept
    function void clear_parser();
      phase      = PH_HEADER;
      offset     = '0;
      img_w      = '0;
      img_h      = '0;
      magic_seen = 1'b0;
      color_lo   = '0;
      col        = '0;
      row        = '0;
    endfunction

    function decoded_result_t make_result(logic [1:0] kind, logic [15:0] w, logic [15:0] h,
                                          logic m, logic [23:0] rgb, logic lp, logic [2:0] st);
      decoded_result_t r;
      r.kind     = kind;
      r.width    = w;
      r.height   = h;
      r.magic    = m;
      r.red      = rgb[7:0];
      r.green    = rgb[15:8];
      r.blue     = rgb[23:16];
      r.last_px  = lp;
      r.status   = st;
      r.last_run = 1'b0;
      return r;
    endfunction

    // Model one accepted input transaction; queue the results it causes.
    function void note_byte(logic [7:0] b, logic eof);
      decoded_result_t run [2];
      int              n;
      logic [OFF_W-1:0] off;
      logic            zero_size;
      logic            last;
      int              rel;
      n         = 0;
      off       = offset;
      zero_size = 1'b0;
      case (phase)
        PH_HEADER: begin
          case (off)
            OFF_MAGIC0:   magic_seen = (b == MAGIC0);
            OFF_MAGIC1:   magic_seen = magic_seen && (b == MAGIC1);
            OFF_WIDTH_L:  img_w = {8'h00, b};
            OFF_WIDTH_H:  img_w[15:8] = b;
            OFF_HEIGHT_L: img_h = {8'h00, b};
            OFF_HEIGHT_H: begin
              img_h[15:8] = b;
              run[n] = make_result(KIND_HEADER, img_w, img_h, magic_seen, '0, 1'b0, ST_OK);
              n++;
              if (img_w == 0 || img_h == 0) begin
                run[n] = make_result(KIND_ERROR, '0, '0, 1'b0, '0, 1'b0, ST_ZERO_SIZE);
                n++;
                phase     = PH_IGNORE;
                zero_size = 1'b1;
              end
            end
            default: ;  // skipped header bytes
          endcase
          offset = off + 1'b1;
          if (phase == PH_HEADER && offset == OFF_W'(PAL_START)) phase = PH_PALETTE;
          if (eof && !zero_size) begin
            run[n] = make_result(KIND_ERROR, '0, '0, 1'b0, '0, 1'b0,
                                 (off < OFF_HEIGHT_H) ? ST_HDR_SHORT : ST_PAL_SHORT);
            n++;
          end
        end
        PH_PALETTE: begin
          rel = int'(off) - PAL_START;
          case (rel % PAL_COMPS)
            COMP_RED:   color_lo = {8'h00, b};
            COMP_GREEN: color_lo[15:8] = b;
            default:    palette[(rel / PAL_COMPS) % PAL_ENTRIES] = {b, color_lo};
          endcase
          offset = off + 1'b1;
          if (int'(offset) >= PAL_END) begin
            phase = PH_PIXELS;
            col   = '0;
            row   = '0;
          end
          if (eof) begin
            run[n] = make_result(KIND_ERROR, '0, '0, 1'b0, '0, 1'b0,
                                 (phase == PH_PALETTE) ? ST_PAL_SHORT : ST_PIX_SHORT);
            n++;
          end
        end
        PH_PIXELS: begin
          last = (int'(col) + 1 == int'(img_w)) && (int'(row) + 1 == int'(img_h));
          run[n] = make_result(KIND_PIXEL, '0, '0, 1'b0, palette[b], last, ST_OK);
          n++;
          if (last) begin
            phase = PH_IGNORE;
          end else begin
            col = col + 16'd1;
            if (col >= img_w) begin
              col = '0;
              row = row + 16'd1;
            end
            if (eof) begin
              run[n] = make_result(KIND_ERROR, '0, '0, 1'b0, '0, 1'b0, ST_PIX_SHORT);
              n++;
            end
          end
        end
        default: ;  // trailing bytes and bytes after a zero-size header
      endcase
      if (n > 0) run[n-1].last_run = 1'b1;
      for (int i = 0; i < n; i++) owed.push_back(run[i]);
      predicted += n;
      if (eof) clear_parser();
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR: result %0d: %s", checked, msg);
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Check one accepted result transaction against the oldest one owed.
    task check_result(decoded_result_t got);
      decoded_result_t want;
      checked++;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result of kind %0d", got.kind));
        return;
      end
      want = owed.pop_front();
      compare_field("kind",        16'(got.kind),     16'(want.kind));
      compare_field("width",       got.width,         want.width);
      compare_field("height",      got.height,        want.height);
      compare_field("magic_ok",    16'(got.magic),    16'(want.magic));
      compare_field("red",         16'(got.red),      16'(want.red));
      compare_field("green",       16'(got.green),    16'(want.green));
      compare_field("blue",        16'(got.blue),     16'(want.blue));
      compare_field("last_pixel",  16'(got.last_px),  16'(want.last_px));
      compare_field("status",      16'(got.status),   16'(want.status));
      compare_field("last_of_run", 16'(got.last_run), 16'(want.last_run));
    endtask

    task finish_check();
      if (owed.size() != 0) report($sformatf("%0d expected results never arrived", owed.size()));
    endtask
  endclass

  // -------------------------------------------------------------------------
  // Signals and the block
  // -------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_file_byte;
  logic        in_end_of_file;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [15:0] out_image_width;
  logic [15:0] out_image_height;
  logic        out_magic_ok;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        out_last_pixel;
  logic [2:0]  out_status;
  logic        out_last_of_run;

  decode_scoreboard sb = new();

  bit gaps_on       = 1'b1;  // random idle bursts on both sides
  bit hold_at_pixels = 1'b0; // ask for the long hold when pixels start
  bit long_hold_req  = 1'b0;
  int bytes_sent     = 0;
  int idle_cycles    = 0;

  indexed_image_palette_decoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_file_byte     (in_file_byte),
    .in_end_of_file   (in_end_of_file),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_image_width  (out_image_width),
    .out_image_height (out_image_height),
    .out_magic_ok     (out_magic_ok),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_last_pixel   (out_last_pixel),
    .out_status       (out_status),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Input side
  // -------------------------------------------------------------------------

  // Offer one byte, hold it until the transaction completes, then maybe idle.
  task automatic send_byte(input logic [7:0] b, input logic eof);
    in_valid       <= 1'b1;
    in_file_byte   <= b;
    in_end_of_file <= eof;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    sb.note_byte(b, eof);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Stream one image file, cut off with end of file at byte index stop_at.
  // Bytes past the size fields are random: skip bytes, palette and pixel indexes.
  task automatic send_image(input logic [15:0] w, input logic [15:0] h,
                            input int magic_mode, input int stop_at);
    for (int i = 0; i <= stop_at; i++) begin
      logic [7:0] b;
      case (i)
        0: b = (magic_mode == MAGIC_BAD_FIRST)  ? MAGIC0 ^ (8'h01 << $urandom_range(0, 7))
                                                : MAGIC0;
        1: b = (magic_mode == MAGIC_BAD_SECOND) ? MAGIC1 ^ (8'h01 << $urandom_range(0, 7))
                                                : MAGIC1;
        2: b = w[7:0];
        3: b = w[15:8];
        4: b = h[7:0];
        5: b = h[15:8];
        default: b = 8'($urandom_range(0, 255));
      endcase
      if (hold_at_pixels && i == PAL_END) begin
        long_hold_req  = 1'b1;
        hold_at_pixels = 1'b0;
      end
      send_byte(b, i == stop_at);
    end
  endtask

  function automatic int pick_magic();
    int r;
    r = $urandom_range(0, 3);
    return (r == 3) ? MAGIC_BAD_SECOND : (r == 2) ? MAGIC_BAD_FIRST : MAGIC_GOOD;
  endfunction

  // -------------------------------------------------------------------------
  // Result side: sample at the edge, check every completed transaction
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(decoded_result_t'{kind: out_kind, width: out_image_width,
                                        height: out_image_height, magic: out_magic_ok,
                                        red: out_red, green: out_green, blue: out_blue,
                                        last_px: out_last_pixel, status: out_status,
                                        last_run: out_last_of_run});
    end
  end

  // ready pattern: mostly high, random stall bursts, one long hold on request
  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: too long without a transaction on either side means a hang.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    int          kind;
    int          rand_start;
    logic [15:0] w;
    logic [15:0] h;
    int          stop_at;

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_file_byte   <= '0;
    in_end_of_file <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: short files around the header.
    send_image(16'h0000, 16'h0000, MAGIC_GOOD, 0);        // end on the very first byte
    send_image(16'hFFFF, 16'hFFFF, MAGIC_GOOD, 3);        // end inside the size fields
    send_image(16'h0000, 16'h0005, MAGIC_BAD_FIRST, 7);   // zero width, bytes then ignored
    send_image(16'hFFFF, 16'hFFFF, MAGIC_GOOD, 5);        // end on header: header + palette short
    send_image(16'h0103, 16'h0000, MAGIC_BAD_SECOND, 5);  // zero height with end of file

    // Whole image while the result side holds off: input must back up.
    hold_at_pixels = 1'b1;
    send_image(16'd16, 16'd8, MAGIC_GOOD, PAL_END + 16 * 8 - 1);

    // Random files, mostly well formed, the rest cut short at every stage.
    rand_start = bytes_sent;
    while (bytes_sent - rand_start < 650) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        // whole file, sometimes with huge sizes cut off early in the pixels
        if ($urandom_range(0, 4) == 0) begin
          w       = 16'($urandom_range(256, 65535));
          h       = 16'($urandom_range(1, 65535));
          stop_at = PAL_END + $urandom_range(0, 12);
        end else begin
          w       = 16'($urandom_range(1, 6));
          h       = 16'($urandom_range(1, 6));
          stop_at = PAL_END + int'(w) * int'(h) - 1 + $urandom_range(0, 3);
        end
      end else if (kind == 6) begin
        // end somewhere in the header, sizes possibly zero
        w       = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom_range(1, 65535));
        h       = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom_range(1, 65535));
        stop_at = $urandom_range(0, PAL_START - 1);
      end else if (kind == 7) begin
        // end in the palette, or exactly on its last byte
        w       = 16'($urandom_range(1, 65535));
        h       = 16'($urandom_range(1, 65535));
        stop_at = ($urandom_range(0, 3) == 0) ? PAL_END - 1
                                              : $urandom_range(PAL_START, PAL_END - 2);
      end else if (kind == 8) begin
        // zero size, followed by up to 35 ignored bytes
        w       = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'($urandom_range(0, 65535));
        h       = (w == 0) ? 16'($urandom_range(0, 65535)) : 16'h0000;
        stop_at = $urandom_range(5, 40);
      end else begin
        // end on a pixel that is not the final one
        w       = 16'($urandom_range(2, 6));
        h       = 16'($urandom_range(1, 4));
        stop_at = PAL_END + $urandom_range(0, int'(w) * int'(h) - 2);
      end
      send_image(w, h, pick_magic(), stop_at);
    end

    // Last part: back-to-back transactions on both sides.
    gaps_on = 1'b0;
    send_image(16'd3, 16'd2, MAGIC_GOOD, PAL_END + 3 * 2 - 1 + 2);
    in_valid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.finish_check();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
